/* design/leso_pkg.sv */
// shared types, constants and observer microprogram for the extended state observer
package leso_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int IN_W           = 32;
  localparam int REG_W          = 31;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int PC_W           = 5;
  // last microprogram address in angle mode
  localparam logic [PC_W-1:0] PC_MAX = PC_W'(27);

  // register indexes of the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MODE    = 3'd0,
    REG_W0      = 3'd1,
    REG_DT      = 3'd2,
    REG_J       = 3'd3,
    REG_JREC    = 3'd4,
    REG_TIN     = 3'd5,
    REG_COMP    = 3'd6,
    REG_UNUSED  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_MOVC,
    OP_CLAMP
  } op_t;

  typedef enum logic [4:0] {
    S_ZERO, S_W0, S_DT, S_J, S_JREC, S_TIN, S_COMP, S_CMD, S_MEAS, S_TEN,
    S_ANG, S_SPD, S_DIST, S_T0, S_T1, S_B1, S_B2, S_B3, S_ACC, S_ERR
  } src_t;

  typedef enum logic [3:0] {
    D_ANG, D_SPD, D_DIST, D_T0, D_T1, D_B1, D_B2, D_B3, D_ACC, D_ERR
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    src_t c;
    dst_t dst;
    logic last;
  } uinst_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DONE
  } st_t;

  function automatic uinst_t mk(op_t op, src_t a, src_t b, src_t c, dst_t d, logic last);
    uinst_t u;
    u.op = op; u.a = a; u.b = b; u.c = c; u.dst = d; u.last = last;
    return u;
  endfunction

  // clamp, torque and compensation, same for both modes
  function automatic uinst_t tail(logic [2:0] k);
    uinst_t u;
    unique case (k)
      3'd0:    u = mk(OP_MUL,   S_JREC, S_TEN,  S_ZERO, D_T1,   1'b0);
      3'd1:    u = mk(OP_CLAMP, S_DIST, S_T1,   S_ZERO, D_DIST, 1'b0);
      3'd2:    u = mk(OP_MUL,   S_J,    S_DIST, S_ZERO, D_T1,   1'b0);
      3'd3:    u = mk(OP_MUL,   S_T1,   S_COMP, S_ZERO, D_T1,   1'b0);
      default: u = mk(OP_SUB,   S_ZERO, S_T1,   S_ZERO, D_T1,   1'b1);
    endcase
    return u;
  endfunction

  // observer program: mode 0 tracks speed, mode 1 tracks angle
  function automatic uinst_t ucode(logic mode, logic [PC_W-1:0] pc);
    uinst_t u;
    if (!mode) begin
      priority case (pc)
        5'd0:  u = mk(OP_MUL,  S_W0,   S_W0,  S_ZERO, D_T0,   1'b0);
        5'd1:  u = mk(OP_MUL,  S_CMD,  S_TIN, S_ZERO, D_T1,   1'b0);
        5'd2:  u = mk(OP_MUL,  S_T1,   S_JREC,S_ZERO, D_T1,   1'b0);
        5'd3:  u = mk(OP_MUL,  S_T1,   S_DT,  S_ZERO, D_ACC,  1'b0);
        5'd4:  u = mk(OP_ADD,  S_W0,   S_W0,  S_ZERO, D_B1,   1'b0);
        5'd5:  u = mk(OP_MOVC, S_MEAS, S_ZERO,S_ZERO, D_SPD,  1'b0);
        5'd6:  u = mk(OP_MUL,  S_DIST, S_DT,  S_ZERO, D_T1,   1'b0);
        5'd7:  u = mk(OP_ADD,  S_SPD,  S_T1,  S_ACC,  D_SPD,  1'b0);
        5'd8:  u = mk(OP_SUB,  S_MEAS, S_SPD, S_ZERO, D_ERR,  1'b0);
        5'd9:  u = mk(OP_MUL,  S_B1,   S_DT,  S_ZERO, D_T1,   1'b0);
        5'd10: u = mk(OP_MUL,  S_T1,   S_ERR, S_ZERO, D_T1,   1'b0);
        5'd11: u = mk(OP_ADD,  S_SPD,  S_T1,  S_ZERO, D_SPD,  1'b0);
        5'd12: u = mk(OP_SUB,  S_MEAS, S_SPD, S_ZERO, D_ERR,  1'b0);
        5'd13: u = mk(OP_MUL,  S_T0,   S_DT,  S_ZERO, D_T1,   1'b0);
        5'd14: u = mk(OP_MUL,  S_T1,   S_ERR, S_ZERO, D_T1,   1'b0);
        5'd15: u = mk(OP_ADD,  S_DIST, S_T1,  S_ZERO, D_DIST, 1'b0);
        default: u = tail(3'(pc - 5'd16));
      endcase
    end else begin
      priority case (pc)
        5'd0:  u = mk(OP_MUL,  S_W0,   S_W0,  S_ZERO, D_T0,   1'b0);
        5'd1:  u = mk(OP_MUL,  S_CMD,  S_TIN, S_ZERO, D_T1,   1'b0);
        5'd2:  u = mk(OP_MUL,  S_T1,   S_JREC,S_ZERO, D_T1,   1'b0);
        5'd3:  u = mk(OP_MUL,  S_T1,   S_DT,  S_ZERO, D_ACC,  1'b0);
        5'd4:  u = mk(OP_ADD,  S_W0,   S_W0,  S_W0,   D_B1,   1'b0);
        5'd5:  u = mk(OP_ADD,  S_T0,   S_T0,  S_T0,   D_B2,   1'b0);
        5'd6:  u = mk(OP_MUL,  S_T0,   S_W0,  S_ZERO, D_B3,   1'b0);
        5'd7:  u = mk(OP_MOVC, S_MEAS, S_ZERO,S_ZERO, D_ANG,  1'b0);
        5'd8:  u = mk(OP_MUL,  S_SPD,  S_DT,  S_ZERO, D_T1,   1'b0);
        5'd9:  u = mk(OP_ADD,  S_ANG,  S_T1,  S_ZERO, D_ANG,  1'b0);
        5'd10: u = mk(OP_MUL,  S_DIST, S_DT,  S_ZERO, D_T1,   1'b0);
        5'd11: u = mk(OP_ADD,  S_SPD,  S_T1,  S_ACC,  D_SPD,  1'b0);
        5'd12: u = mk(OP_SUB,  S_MEAS, S_ANG, S_ZERO, D_ERR,  1'b0);
        5'd13: u = mk(OP_MUL,  S_B1,   S_DT,  S_ZERO, D_T1,   1'b0);
        5'd14: u = mk(OP_MUL,  S_T1,   S_ERR, S_ZERO, D_T1,   1'b0);
        5'd15: u = mk(OP_ADD,  S_ANG,  S_T1,  S_ZERO, D_ANG,  1'b0);
        5'd16: u = mk(OP_SUB,  S_MEAS, S_ANG, S_ZERO, D_ERR,  1'b0);
        5'd17: u = mk(OP_MUL,  S_B2,   S_DT,  S_ZERO, D_T1,   1'b0);
        5'd18: u = mk(OP_MUL,  S_T1,   S_ERR, S_ZERO, D_T1,   1'b0);
        5'd19: u = mk(OP_ADD,  S_SPD,  S_T1,  S_ZERO, D_SPD,  1'b0);
        5'd20: u = mk(OP_MUL,  S_B3,   S_DT,  S_ZERO, D_T1,   1'b0);
        5'd21: u = mk(OP_MUL,  S_T1,   S_ERR, S_ZERO, D_T1,   1'b0);
        5'd22: u = mk(OP_ADD,  S_DIST, S_T1,  S_ZERO, D_DIST, 1'b0);
        default: u = tail(3'(pc - 5'd23));
      endcase
    end
    return u;
  endfunction

endpackage

/* design/leso_mul.sv */
// iterative fixed point multiplier: 16 bits of one operand per cycle, rounding and saturation
module leso_mul #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] p
);
  localparam int DW  = DATA_WIDTH;
  localparam int NCH = (DW + 15) / 16;
  localparam int BW  = NCH * 16;
  localparam int PW  = DW + BW;
  localparam int CW  = $clog2(NCH + 1);
  localparam logic [PW:0] RND  = (PW+1)'(1) << (FRAC_BITS - 1);
  localparam logic [PW:0] HALF = (PW+1)'(1) << (DW - 1);
  localparam logic signed [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};

  logic [DW-1:0]  ua;
  logic [BW-1:0]  ub;
  logic [PW-1:0]  acc;
  logic           neg;
  logic           busy;
  logic [CW-1:0]  cnt;
  logic [PW:0]    rsum;
  logic [PW:0]    res;

  // magnitude load, then partial products from the top chunk down
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(NCH);
      neg  <= a[DW-1] ^ b[DW-1];
      ua   <= a[DW-1] ? DW'(-a) : DW'(a);
      ub   <= b[DW-1] ? BW'(DW'(-b)) : BW'(DW'(b));
      acc  <= '0;
    end else if (busy) begin
      acc <= (acc << 16) + PW'((DW+16)'(ua) * (DW+16)'(ub[BW-1 -: 16]));
      ub  <= ub << 16;
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // round half away from zero, then saturate with sign
  always_comb begin
    rsum = (PW+1)'(acc) + RND;
    res  = rsum >> FRAC_BITS;
    if (neg) begin
      p = (res >= HALF) ? QMIN : -DW'(res);
    end else begin
      p = (res > (PW+1)'(QMAX)) ? QMAX : DW'(res);
    end
  end

  // done pulses for one cycle, never while chunks remain
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("multiplier done longer than one cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("multiplier running with no chunk left");

endmodule

/* design/linear_extended_state_observer.sv */
// linear extended state observer top level: configuration, sequencer and shared datapath
//
// channel  | direction | request moves
// s_axis   | in        | command_torque, measurement (tdata), restart (tuser)
// m_axis   | out       | comp_cmd, angle/speed/disturbance estimates (tdata)
// cfg      | in        | register index and write data
//
// One tick takes 21 microsteps in speed mode and 28 in angle mode; each multiply
// step waits on the shared multiplier, the other steps write their ALU result
// directly, and each tick is framed by the idle (accept) and done (result) states.
// Reset is synchronous and restores the register defaults and zero estimates.
// A new request is taken only in idle; a result held on m_axis stalls the
// next result but not the acceptance of the next request.
module linear_extended_state_observer #(
  parameter int FRAC_BITS  = leso_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = leso_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [2*leso_pkg::IN_W-1:0]            s_tdata,  // command_torque, measurement
  input  logic                                   s_tuser,  // restart
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // comp_cmd, angle_estimate, speed_estimate, disturbance_estimate
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      m_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [leso_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [leso_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import leso_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int OUT_W = ((4*DW+7)/8)*8;
  localparam int EW    = ((DW > IN_W) ? DW : IN_W) + 1;
  localparam logic signed [EW-1:0] QMAXE = EW'((64'sd1 <<< (DW-1)) - 64'sd1);
  localparam logic signed [EW-1:0] QMINE = -QMAXE - EW'(1);
  localparam logic signed [DW-1:0] QMAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] QMIN  = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] TEN   = DW'(64'sd10 <<< FRAC_BITS);

  st_t state, state_next;

  // configuration registers
  logic             r_mode;
  logic [REG_W-1:0] r_w0, r_dt, r_j, r_jrec, r_tin, r_comp;

  // tick inputs and observer state
  logic [IN_W-1:0]      cmd, meas;
  logic signed [DW-1:0] ang, spd, dist_est, t0, t1, b1, b2, b3, acc, err;
  logic                 initialised;
  logic [PC_W-1:0]      pc;

  uinst_t               ui;
  logic signed [DW-1:0] opa, opb, opc, alu_res, wdata;
  logic signed [DW+1:0] sum;
  logic                 mul_start, mul_done, alu_we, mul_we, out_load, wr_en;
  logic signed [DW-1:0] mul_p;

  function automatic logic signed [DW-1:0] sat_u(logic [REG_W-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    return (e > QMAXE) ? QMAX : DW'(e);
  endfunction

  function automatic logic signed [DW-1:0] sat_s(logic [IN_W-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(signed'(v));
    if (e > QMAXE) return QMAX;
    if (e < QMINE) return QMIN;
    return DW'(e);
  endfunction

  function automatic logic signed [DW-1:0] rd(src_t s);
    logic signed [DW-1:0] v;
    unique case (s)
      S_ZERO: v = '0;
      S_W0:   v = sat_u(r_w0);
      S_DT:   v = sat_u(r_dt);
      S_J:    v = sat_u(r_j);
      S_JREC: v = sat_u(r_jrec);
      S_TIN:  v = sat_u(r_tin);
      S_COMP: v = sat_u(r_comp);
      S_CMD:  v = sat_s(cmd);
      S_MEAS: v = sat_s(meas);
      S_TEN:  v = TEN;
      S_ANG:  v = ang;
      S_SPD:  v = spd;
      S_DIST: v = dist_est;
      S_T0:   v = t0;
      S_T1:   v = t1;
      S_B1:   v = b1;
      S_B2:   v = b2;
      S_B3:   v = b3;
      S_ACC:  v = acc;
      S_ERR:  v = err;
      default: v = '0;
    endcase
    return v;
  endfunction

  // microinstruction and operand fetch
  always_comb begin
    ui  = ucode(r_mode, pc);
    opa = rd(ui.a);
    opb = rd(ui.b);
    opc = rd(ui.c);
  end

  // add, subtract, conditional load and clamp
  always_comb begin
    sum = '0;
    unique case (ui.op)
      OP_SUB:  sum = (DW+2)'(opa) - (DW+2)'(opb);
      default: sum = (DW+2)'(opa) + (DW+2)'(opb) + (DW+2)'(opc);
    endcase
    priority if (ui.op == OP_CLAMP) begin
      if (opa > opb)       alu_res = opb;
      else if (opa < -opb) alu_res = -opb;
      else                 alu_res = opa;
    end else if (ui.op == OP_MOVC) begin
      alu_res = opa;
    end else if (sum > (DW+2)'(QMAX)) begin
      alu_res = QMAX;
    end else if (sum < (DW+2)'(QMIN)) begin
      alu_res = QMIN;
    end else begin
      alu_res = DW'(sum);
    end
  end

  leso_mul #(
    .FRAC_BITS  (FRAC_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .p     (mul_p)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (ui.op == OP_MUL) state_next = ST_MUL;
        else if (ui.last)    state_next = ST_DONE;
      end
      ST_MUL: if (mul_done) state_next = ui.last ? ST_DONE : ST_EXEC;
      ST_DONE: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
    mul_start = (state == ST_EXEC) && (ui.op == OP_MUL);
    alu_we    = (state == ST_EXEC) && (ui.op != OP_MUL);
    mul_we    = (state == ST_MUL) && mul_done;
    out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  assign wdata = mul_we ? mul_p : alu_res;
  assign wr_en = mul_we || (alu_we && !(ui.op == OP_MOVC && initialised));

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      r_mode <= 1'b0;
      r_w0   <= '0;
      r_dt   <= REG_W'(655);
      r_j    <= REG_W'(65536);
      r_jrec <= REG_W'(65536);
      r_tin  <= REG_W'(65536);
      r_comp <= REG_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_MODE: r_mode <= cfg_data[0];
        REG_W0:   r_w0   <= cfg_data[REG_W-1:0];
        REG_DT:   r_dt   <= cfg_data[REG_W-1:0];
        REG_J:    r_j    <= cfg_data[REG_W-1:0];
        REG_JREC: r_jrec <= cfg_data[REG_W-1:0];
        REG_TIN:  r_tin  <= cfg_data[REG_W-1:0];
        REG_COMP: r_comp <= cfg_data[REG_W-1:0];
        default:  ;
      endcase
    end
  end

  // sequencer, request capture and initialised mark
  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= '0;
      initialised <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      pc   <= '0;
      cmd  <= s_tdata[IN_W-1:0];
      meas <= s_tdata[2*IN_W-1:IN_W];
      if (s_tuser) initialised <= 1'b0;
    end else if (alu_we || mul_we) begin
      pc <= pc + PC_W'(1);
      if (alu_we && ui.op == OP_MOVC) initialised <= 1'b1;
    end
  end

  // estimate and scratch registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ang      <= '0;
      spd      <= '0;
      dist_est <= '0;
    end else if (wr_en) begin
      unique case (ui.dst)
        D_ANG:  ang      <= wdata;
        D_SPD:  spd      <= wdata;
        D_DIST: dist_est <= wdata;
        D_T0:   t0   <= wdata;
        D_T1:   t1   <= wdata;
        D_B1:   b1   <= wdata;
        D_B2:   b2   <= wdata;
        D_B3:   b3   <= wdata;
        D_ACC:  acc  <= wdata;
        D_ERR:  err  <= wdata;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= OUT_W'({dist_est, spd, ang, t1});
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
      (state == ST_EXEC) |-> (pc <= PC_MAX))
    else $error("microprogram counter past end");
  a_init_done: assert property (@(posedge clk) disable iff (rst)
      (state == ST_DONE) |-> initialised)
    else $error("tick finished without initialised mark");
  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
      mul_done |-> (state == ST_MUL))
    else $error("multiplier result outside multiply wait");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      (state == ST_DONE && m_tvalid && !m_tready) |=> (state == ST_DONE))
    else $error("result dropped while output stalled");

endmodule
